@@ design/hfe_pkg.sv @@
package hfe_pkg;

  localparam int PIXEL_PORT_W = 8;
  localparam int TYPE_W       = 3;
  localparam int GEOM_W       = 5;
  localparam int VALUE_W      = 19;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [TYPE_W-1:0] FT_TWO_H   = 3'd1;
  localparam logic [TYPE_W-1:0] FT_THREE_H = 3'd2;
  localparam logic [TYPE_W-1:0] FT_TWO_V   = 3'd3;
  localparam logic [TYPE_W-1:0] FT_THREE_V = 3'd4;
  localparam logic [TYPE_W-1:0] FT_CHECKER = 3'd5;

  typedef struct packed {
    logic                    kind;
    logic [PIXEL_PORT_W-1:0] pixel;
    logic                    fits;
    logic [TYPE_W-1:0]       ftype;
    logic [GEOM_W-1:0]       top_row;
    logic [GEOM_W-1:0]       left_col;
    logic [GEOM_W-1:0]       cell_height;
    logic [GEOM_W-1:0]       cell_width;
    logic [1:0]              cells_down;
    logic [1:0]              cells_across;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               out_of_window;
  } result_t;

  typedef struct packed {
    logic       nz;
    logic       neg;
    logic [1:0] shift;
  } weight_t;

  function automatic int cell_sign(logic [TYPE_W-1:0] t, int i, int j);
    int s;
    s = 0;
    if (i >= 0 && j >= 0) begin
      if (t == FT_TWO_H && i == 0) begin
        s = (j == 0) ? 1 : (j == 1) ? -1 : 0;
      end else if (t == FT_THREE_H && i == 0) begin
        s = (j == 0) ? 1 : (j == 1) ? -1 : (j == 2) ? 1 : 0;
      end else if (t == FT_TWO_V && j == 0) begin
        s = (i == 0) ? 1 : (i == 1) ? -1 : 0;
      end else if (t == FT_THREE_V && j == 0) begin
        s = (i == 0) ? 1 : (i == 1) ? -1 : (i == 2) ? 1 : 0;
      end else if (t == FT_CHECKER && i < 2 && j < 2) begin
        s = (i == j) ? 1 : -1;
      end
    end
    return s;
  endfunction

  // weight of the corner on row line a, column line b
  function automatic weight_t corner_weight(logic [TYPE_W-1:0] t, logic [1:0] a,
                                            logic [1:0] b);
    int ai;
    int bi;
    int w;
    int mag;
    weight_t r;
    ai = int'(a);
    bi = int'(b);
    w = cell_sign(t, ai - 1, bi - 1) - cell_sign(t, ai, bi - 1)
      - cell_sign(t, ai - 1, bi) + cell_sign(t, ai, bi);
    mag = (w < 0) ? -w : w;
    r.nz = (w != 0);
    r.neg = (w < 0);
    r.shift = (mag >= 4) ? 2'd2 : (mag >= 2) ? 2'd1 : 2'd0;
    return r;
  endfunction

endpackage

@@ design/hfe_ram.sv @@
module hfe_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 576
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/hfe_front.sv @@
module hfe_front #(
  parameter int WINDOW_SIZE = 24,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              kind,
  input  logic [hfe_pkg::PIXEL_PORT_W-1:0]  pixel,
  input  logic [hfe_pkg::TYPE_W-1:0]        feature_type,
  input  logic [hfe_pkg::GEOM_W-1:0]        top_row,
  input  logic [hfe_pkg::GEOM_W-1:0]        left_col,
  input  logic [hfe_pkg::GEOM_W-1:0]        cell_height,
  input  logic [hfe_pkg::GEOM_W-1:0]        cell_width,
  output logic                              q_valid,
  output hfe_pkg::item_t                    q_item,
  input  logic                              q_take
);

  localparam int PIX_W = (PIXEL_BITS < hfe_pkg::PIXEL_PORT_W) ? PIXEL_BITS
                                                              : hfe_pkg::PIXEL_PORT_W;
  localparam logic [hfe_pkg::PIXEL_PORT_W-1:0] PIX_MASK =
    hfe_pkg::PIXEL_PORT_W'((32'd1 << PIX_W) - 32'd1);

  hfe_pkg::item_t item;
  hfe_pkg::item_t slots [2];
  logic [1:0]     down;
  logic [1:0]     across;
  logic           type_ok;
  logic [7:0]     span_r;
  logic [7:0]     span_c;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           accept;

  always_comb begin
    type_ok = 1'b1;
    unique case (feature_type)
      hfe_pkg::FT_TWO_H:   begin down = 2'd1; across = 2'd2; end
      hfe_pkg::FT_THREE_H: begin down = 2'd1; across = 2'd3; end
      hfe_pkg::FT_TWO_V:   begin down = 2'd2; across = 2'd1; end
      hfe_pkg::FT_THREE_V: begin down = 2'd3; across = 2'd1; end
      hfe_pkg::FT_CHECKER: begin down = 2'd2; across = 2'd2; end
      default: begin
        type_ok = 1'b0;
        down = 2'd0;
        across = 2'd0;
      end
    endcase
    span_r = 8'(top_row) + 8'(down) * 8'(cell_height);
    span_c = 8'(left_col) + 8'(across) * 8'(cell_width);
    item.kind = kind;
    item.pixel = pixel & PIX_MASK;
    item.fits = type_ok && cell_height != '0 && cell_width != '0
             && span_r <= 8'(WINDOW_SIZE) && span_c <= 8'(WINDOW_SIZE);
    item.ftype = feature_type;
    item.top_row = top_row;
    item.left_col = left_col;
    item.cell_height = cell_height;
    item.cell_width = cell_width;
    item.cells_down = down;
    item.cells_across = across;
  end

  assign full    = (count == 2'd2);
  assign accept  = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept) begin
        slots[wr_ptr] <= item;
        wr_ptr <= !wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(accept) - 2'(q_take);
    end
  end

endmodule

@@ design/hfe_result_queue.sv @@
module hfe_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_push,
  input  hfe_pkg::result_t res_data,
  output logic             res_full,
  input  logic             pop,
  output logic             empty,
  output hfe_pkg::result_t head
);

  hfe_pkg::result_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             take;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign take     = pop && !empty;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (res_push) begin
        slots[wr_ptr] <= res_data;
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(res_push) - 2'(take);
    end
  end

endmodule

@@ design/hfe_back.sv @@
module hfe_back #(
  parameter int WINDOW_SIZE = 24,
  parameter int PIXEL_BITS  = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  hfe_pkg::item_t   q_item,
  output logic             q_take,
  output logic             res_push,
  output hfe_pkg::result_t res_data,
  input  logic             res_full
);

  localparam int PIX_W = (PIXEL_BITS < hfe_pkg::PIXEL_PORT_W) ? PIXEL_BITS
                                                              : hfe_pkg::PIXEL_PORT_W;
  localparam int CELLS  = WINDOW_SIZE * WINDOW_SIZE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int POS_W  = $clog2(WINDOW_SIZE);
  localparam int RP_W   = $clog2(WINDOW_SIZE + 1);
  localparam int RS_W   = PIX_W + POS_W;
  localparam int SUM_W  = PIX_W + ADDR_W;
  localparam int ACC_W  = (SUM_W + 3 > hfe_pkg::VALUE_W) ? SUM_W + 3 : hfe_pkg::VALUE_W;

  typedef enum logic [2:0] {
    IDLE,
    LD_RD,
    LD_WR,
    EV_RUN,
    EV_DRAIN,
    EV_PUSH
  } state_t;

  state_t           state;
  logic [POS_W-1:0] lrow;
  logic [POS_W-1:0] lcol;
  logic [ADDR_W-1:0] laddr;
  logic [RS_W-1:0]  rowsum;
  logic [PIX_W-1:0] pix;
  hfe_pkg::item_t   cur;
  logic [1:0]       a;
  logic [1:0]       b;
  logic [RP_W-1:0]  rp;
  logic [RP_W-1:0]  cp;
  logic             pend;
  hfe_pkg::weight_t pend_w;
  logic [ACC_W-1:0] acc;

  hfe_pkg::weight_t wt;
  logic             issue;
  logic [ADDR_W-1:0] ev_addr;
  logic [ADDR_W-1:0] above_addr;
  logic             ram_re;
  logic             ram_we;
  logic [ADDR_W-1:0] raddr;
  logic [SUM_W-1:0] rdata;
  logic [SUM_W-1:0] wdata;
  logic [SUM_W-1:0] above;
  logic [RS_W-1:0]  rs_new;
  logic [ACC_W-1:0] term;
  logic [ACC_W-1:0] acc_add;

  always_comb begin
    wt = hfe_pkg::corner_weight(cur.ftype, a, b);
    issue = (state == EV_RUN) && rp != '0 && cp != '0 && wt.nz;
    ev_addr = ADDR_W'((rp - 1'b1) * WINDOW_SIZE) + ADDR_W'(cp - 1'b1);
    above_addr = laddr - ADDR_W'(WINDOW_SIZE);
    ram_re = issue || (state == LD_RD && lrow != '0);
    raddr = (state == LD_RD) ? above_addr : ev_addr;
    above = (lrow != '0) ? rdata : '0;
    rs_new = (lcol == '0) ? RS_W'(pix) : rowsum + RS_W'(pix);
    ram_we = (state == LD_WR);
    wdata = SUM_W'(rs_new) + above;
    term = ACC_W'(rdata) << pend_w.shift;
    acc_add = !pend ? acc : pend_w.neg ? acc - term : acc + term;

    q_take = (state == IDLE) && q_valid
          && (q_item.kind == hfe_pkg::KIND_LOAD || !res_full);
    res_push = (state == EV_PUSH)
            || (q_take && q_item.kind == hfe_pkg::KIND_EVAL && !q_item.fits);
    res_data.value = (state == EV_PUSH) ? acc[hfe_pkg::VALUE_W-1:0] : '0;
    res_data.out_of_window = (state != EV_PUSH);
  end

  hfe_ram #(
    .WIDTH(SUM_W),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(laddr),
    .wdata(wdata),
    .re   (ram_re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      lrow <= '0;
      lcol <= '0;
      laddr <= '0;
      rowsum <= '0;
      pend <= 1'b0;
    end else begin
      pend <= issue;
      pend_w <= wt;
      acc <= (state == IDLE) ? '0 : acc_add;
      unique case (state)
        IDLE: begin
          if (q_take) begin
            if (q_item.kind == hfe_pkg::KIND_LOAD) begin
              pix <= q_item.pixel[PIX_W-1:0];
              state <= LD_RD;
            end else if (q_item.fits) begin
              cur <= q_item;
              a <= 2'd0;
              b <= 2'd0;
              rp <= RP_W'(q_item.top_row);
              cp <= RP_W'(q_item.left_col);
              state <= EV_RUN;
            end
          end
        end
        LD_RD: begin
          state <= LD_WR;
        end
        LD_WR: begin
          rowsum <= rs_new;
          if (lcol == POS_W'(WINDOW_SIZE - 1)) begin
            lcol <= '0;
            if (lrow == POS_W'(WINDOW_SIZE - 1)) begin
              lrow <= '0;
              laddr <= '0;
            end else begin
              lrow <= lrow + 1'b1;
              laddr <= laddr + 1'b1;
            end
          end else begin
            lcol <= lcol + 1'b1;
            laddr <= laddr + 1'b1;
          end
          state <= IDLE;
        end
        EV_RUN: begin
          if (b == cur.cells_across) begin
            b <= 2'd0;
            cp <= RP_W'(cur.left_col);
            if (a == cur.cells_down) begin
              state <= EV_DRAIN;
            end else begin
              a <= a + 1'b1;
              rp <= rp + RP_W'(cur.cell_height);
            end
          end else begin
            b <= b + 1'b1;
            cp <= cp + RP_W'(cur.cell_width);
          end
        end
        EV_DRAIN: begin
          state <= EV_PUSH;
        end
        EV_PUSH: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result pushed into a full queue");

  assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("store read and written in one cycle");

  assert property (@(posedge clk) disable iff (rst) pend |-> $past(state == EV_RUN))
    else $error("corner data pending outside an evaluation");

  assert property (@(posedge clk) disable iff (rst)
    (state == EV_PUSH) |-> $past(state == EV_DRAIN))
    else $error("feature result pushed before the last corner drained");

endmodule

@@ design/haar_feature_evaluator_core.sv @@
// Haar feature evaluator over one square window.
// Input channel: drive the item fields with push high; a word is taken at a
// clock edge where push is high and full is low. A load word (kind 0) adds
// the next pixel of the window in raster order to the integral image; an
// evaluate word (kind 1) names a feature type, top-left corner and cell size.
// Result channel: while empty is low, feature_value and out_of_window hold
// the oldest result; pop with empty low takes it. Only evaluate words give a
// result. A stalled receiver fills the two-word result queue, after which
// evaluate words wait in the two-word input queue and full rises.
// Each word passes through the back end alone, which has a single read port
// on its integral store: a load word reads the integral sum above its pixel
// (none on the first row), then writes the new sum; an evaluate word steps the
// corner sequencer over every row and column of corners, drains the last corner
// read and pushes its result. A feature that does not fit is answered at once.
// Reset clears the queues and the raster position; the integral store is
// not cleared, so evaluate only over pixels already loaded.
module haar_feature_evaluator_core #(
  parameter int WINDOW_SIZE = 24,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  output logic                                    full,
  input  logic                                    kind,
  input  logic [hfe_pkg::PIXEL_PORT_W-1:0]        pixel,
  input  logic [hfe_pkg::TYPE_W-1:0]              feature_type,
  input  logic [hfe_pkg::GEOM_W-1:0]              top_row,
  input  logic [hfe_pkg::GEOM_W-1:0]              left_col,
  input  logic [hfe_pkg::GEOM_W-1:0]              cell_height,
  input  logic [hfe_pkg::GEOM_W-1:0]              cell_width,
  input  logic                                    pop,
  output logic                                    empty,
  output logic signed [hfe_pkg::VALUE_W-1:0]      feature_value,
  output logic                                    out_of_window
);

  logic             q_valid;
  hfe_pkg::item_t   q_item;
  logic             q_take;
  logic             res_push;
  hfe_pkg::result_t res_data;
  logic             res_full;
  hfe_pkg::result_t head;

  hfe_front #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .pixel       (pixel),
    .feature_type(feature_type),
    .top_row     (top_row),
    .left_col    (left_col),
    .cell_height (cell_height),
    .cell_width  (cell_width),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_take      (q_take)
  );

  hfe_back #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take),
    .res_push(res_push),
    .res_data(res_data),
    .res_full(res_full)
  );

  hfe_result_queue u_results (
    .clk     (clk),
    .rst     (rst),
    .res_push(res_push),
    .res_data(res_data),
    .res_full(res_full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  assign feature_value = head.value;
  assign out_of_window = head.out_of_window;

endmodule

@@ dv/haar_feature_evaluator_core_tb.sv @@
`timescale 1ns / 100ps

module haar_feature_evaluator_core_tb;

  localparam int WIN = 24;
  localparam int CELLS = WIN * WIN;
  localparam int RANDOM_WORDS = 900;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;

  localparam logic [hfe_pkg::TYPE_W-1:0] FT_NONE    = 3'd0;
  localparam logic [hfe_pkg::TYPE_W-1:0] FT_SPARE_A = 3'd6;
  localparam logic [hfe_pkg::TYPE_W-1:0] FT_SPARE_B = 3'd7;

  typedef enum int {PIX_NOISE, PIX_WHITE, PIX_BLACK, PIX_SPECKLE} pix_style_t;

  typedef struct packed {
    logic                             kind;
    logic [hfe_pkg::PIXEL_PORT_W-1:0] pixel;
    logic [hfe_pkg::TYPE_W-1:0]       ftype;
    logic [hfe_pkg::GEOM_W-1:0]       top_row;
    logic [hfe_pkg::GEOM_W-1:0]       left_col;
    logic [hfe_pkg::GEOM_W-1:0]       cell_height;
    logic [hfe_pkg::GEOM_W-1:0]       cell_width;
  } word_t;

  typedef struct packed {
    logic [hfe_pkg::VALUE_W-1:0] value;
    logic                        out_of_window;
  } feature_t;

  class feature_tracker;
    logic [17:0] integral [CELLS];
    logic [12:0] row_sum;
    int          raster_pos;
    feature_t    expected_features[$];
    int          mismatches;

    function new();
      foreach (integral[i]) integral[i] = '0;
      row_sum = '0;
      raster_pos = 0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endfunction

    function int pending();
      return expected_features.size();
    endfunction

    function int corner_sum(int r, int c);
      if (r < 0 || c < 0 || r >= WIN || c >= WIN) return 0;
      return int'(integral[r * WIN + c]);
    endfunction

    function int box_sum(int t, int l, int h, int w);
      return corner_sum(t + h - 1, l + w - 1) - corner_sum(t - 1, l + w - 1)
           - corner_sum(t + h - 1, l - 1) + corner_sum(t - 1, l - 1);
    endfunction

    function void add_pixel(logic [hfe_pkg::PIXEL_PORT_W-1:0] pix);
      int r;
      r = raster_pos / WIN;
      if (raster_pos % WIN == 0) begin
        row_sum = 13'(pix);
      end else begin
        row_sum = row_sum + 13'(pix);
      end
      integral[raster_pos] = 18'(row_sum) + ((r > 0) ? integral[raster_pos - WIN] : 18'd0);
      raster_pos = (raster_pos + 1) % CELLS;
    endfunction

    function feature_t predict_feature(word_t wd);
      int t, l, h, w, nh, nw, v;
      feature_t f;
      t = wd.top_row;
      l = wd.left_col;
      h = wd.cell_height;
      w = wd.cell_width;
      nh = 0;
      nw = 0;
      v = 0;
      case (wd.ftype)
        hfe_pkg::FT_TWO_H: begin nh = 1; nw = 2; end
        hfe_pkg::FT_THREE_H: begin nh = 1; nw = 3; end
        hfe_pkg::FT_TWO_V: begin nh = 2; nw = 1; end
        hfe_pkg::FT_THREE_V: begin nh = 3; nw = 1; end
        hfe_pkg::FT_CHECKER: begin nh = 2; nw = 2; end
        default: ;
      endcase
      f.value = '0;
      f.out_of_window = 1'b1;
      if (nh > 0 && h > 0 && w > 0 && t + nh * h <= WIN && l + nw * w <= WIN) begin
        case (wd.ftype)
          hfe_pkg::FT_TWO_H: v = box_sum(t, l, h, w) - box_sum(t, l + w, h, w);
          hfe_pkg::FT_THREE_H: v = box_sum(t, l, h, w) - box_sum(t, l + w, h, w)
                                 + box_sum(t, l + 2 * w, h, w);
          hfe_pkg::FT_TWO_V: v = box_sum(t, l, h, w) - box_sum(t + h, l, h, w);
          hfe_pkg::FT_THREE_V: v = box_sum(t, l, h, w) - box_sum(t + h, l, h, w)
                                 + box_sum(t + 2 * h, l, h, w);
          default: v = box_sum(t, l, h, w) - box_sum(t + h, l, h, w)
                     - box_sum(t, l + w, h, w) + box_sum(t + h, l + w, h, w);
        endcase
        f.value = hfe_pkg::VALUE_W'(v);
        f.out_of_window = 1'b0;
      end
      return f;
    endfunction

    function void take_word(word_t wd);
      if (wd.kind == hfe_pkg::KIND_LOAD) begin
        add_pixel(wd.pixel);
      end else begin
        expected_features.push_back(predict_feature(wd));
      end
    endfunction

    function void check_feature(logic [hfe_pkg::VALUE_W-1:0] value, logic oow);
      feature_t want;
      if (expected_features.size() == 0) begin
        flag($sformatf("result with none pending: value %0d oow %b", $signed(value), oow));
        return;
      end
      want = expected_features.pop_front();
      if (value !== want.value) begin
        flag($sformatf("feature_value expected %0d got %0d",
                       $signed(want.value), $signed(value)));
      end
      if (oow !== want.out_of_window) begin
        flag($sformatf("out_of_window expected %b got %b", want.out_of_window, oow));
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst;
  logic                               push;
  logic                               full;
  logic                               kind;
  logic [hfe_pkg::PIXEL_PORT_W-1:0]   pixel;
  logic [hfe_pkg::TYPE_W-1:0]         feature_type;
  logic [hfe_pkg::GEOM_W-1:0]         top_row;
  logic [hfe_pkg::GEOM_W-1:0]         left_col;
  logic [hfe_pkg::GEOM_W-1:0]         cell_height;
  logic [hfe_pkg::GEOM_W-1:0]         cell_width;
  logic                               pop = 1'b0;
  logic                               empty;
  logic signed [hfe_pkg::VALUE_W-1:0] feature_value;
  logic                               out_of_window;

  feature_tracker tracker;
  bit no_gaps = 1'b0;
  int pop_hold = 0;
  int stall_cycles = 0;
  int words_sent = 0;
  int load_count = 0;

  haar_feature_evaluator_core dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .kind(kind),
    .pixel(pixel),
    .feature_type(feature_type),
    .top_row(top_row),
    .left_col(left_col),
    .cell_height(cell_height),
    .cell_width(cell_width),
    .pop(pop),
    .empty(empty),
    .feature_value(feature_value),
    .out_of_window(out_of_window)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if (!no_gaps && $urandom_range(0, 299) == 0) begin
      pop_hold = $urandom_range(8, 40);
      pop <= 1'b0;
    end else begin
      pop <= no_gaps || ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        tracker.take_word({kind, pixel, feature_type, top_row, left_col,
                           cell_height, cell_width});
      end
      if (pop && !empty) begin
        tracker.check_feature(feature_value, out_of_window);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic word_t random_word(logic k);
    word_t wd;
    wd = word_t'($urandom);
    wd.kind = k;
    return wd;
  endfunction

  function automatic word_t fitting_feature();
    word_t wd;
    int nh, nw, h, w;
    wd = random_word(hfe_pkg::KIND_EVAL);
    case ($urandom_range(0, 4))
      0: begin wd.ftype = hfe_pkg::FT_TWO_H; nh = 1; nw = 2; end
      1: begin wd.ftype = hfe_pkg::FT_THREE_H; nh = 1; nw = 3; end
      2: begin wd.ftype = hfe_pkg::FT_TWO_V; nh = 2; nw = 1; end
      3: begin wd.ftype = hfe_pkg::FT_THREE_V; nh = 3; nw = 1; end
      default: begin wd.ftype = hfe_pkg::FT_CHECKER; nh = 2; nw = 2; end
    endcase
    h = $urandom_range(1, WIN / nh);
    w = $urandom_range(1, WIN / nw);
    wd.cell_height = hfe_pkg::GEOM_W'(h);
    wd.cell_width = hfe_pkg::GEOM_W'(w);
    wd.top_row = hfe_pkg::GEOM_W'($urandom_range(0, WIN - nh * h));
    wd.left_col = hfe_pkg::GEOM_W'($urandom_range(0, WIN - nw * w));
    return wd;
  endfunction

  function automatic logic [hfe_pkg::PIXEL_PORT_W-1:0] pixel_for(pix_style_t style);
    case (style)
      PIX_WHITE: return '1;
      PIX_BLACK: return '0;
      PIX_SPECKLE: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return hfe_pkg::PIXEL_PORT_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input word_t wd);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 24) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push <= 1'b1;
    kind <= wd.kind;
    pixel <= wd.pixel;
    feature_type <= wd.ftype;
    top_row <= wd.top_row;
    left_col <= wd.left_col;
    cell_height <= wd.cell_height;
    cell_width <= wd.cell_width;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
    if (wd.kind == hfe_pkg::KIND_LOAD) begin
      load_count = (load_count + 1) % CELLS;
    end
  endtask

  task automatic send_load(input logic [hfe_pkg::PIXEL_PORT_W-1:0] pix);
    word_t wd;
    wd = random_word(hfe_pkg::KIND_LOAD);
    wd.pixel = pix;
    send_word(wd);
  endtask

  task automatic send_eval(input logic [hfe_pkg::TYPE_W-1:0] ft, input int r, input int c,
                           input int h, input int w);
    word_t wd;
    wd = random_word(hfe_pkg::KIND_EVAL);
    wd.ftype = ft;
    wd.top_row = hfe_pkg::GEOM_W'(r);
    wd.left_col = hfe_pkg::GEOM_W'(c);
    wd.cell_height = hfe_pkg::GEOM_W'(h);
    wd.cell_width = hfe_pkg::GEOM_W'(w);
    send_word(wd);
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int random_start;
    int roll;
    int burst;
    bit mid_pause_done;
    pix_style_t style;

    tracker = new();
    mid_pause_done = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    kind = hfe_pkg::KIND_LOAD;
    pixel = '0;
    feature_type = '0;
    top_row = '0;
    left_col = '0;
    cell_height = '0;
    cell_width = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // quadrant checkerboard window
    for (int i = 0; i < CELLS; i++) begin
      send_load(((i / WIN < WIN / 2) == (i % WIN < WIN / 2)) ? 8'hff : 8'h00);
    end

    send_eval(hfe_pkg::FT_TWO_H, 0, 0, 12, 12);
    send_eval(hfe_pkg::FT_TWO_H, 12, 0, 12, 12);
    send_eval(hfe_pkg::FT_TWO_H, 0, 0, 24, 12);
    send_eval(hfe_pkg::FT_THREE_H, 0, 0, 24, 8);
    send_eval(hfe_pkg::FT_TWO_V, 0, 0, 12, 12);
    send_eval(hfe_pkg::FT_THREE_V, 0, 0, 8, 24);
    send_eval(hfe_pkg::FT_THREE_V, 0, 0, 8, 12);
    send_eval(hfe_pkg::FT_CHECKER, 0, 0, 12, 12);
    send_eval(hfe_pkg::FT_CHECKER, 6, 6, 6, 6);
    send_eval(hfe_pkg::FT_TWO_H, 0, 0, 1, 1);
    send_eval(hfe_pkg::FT_TWO_H, 23, 22, 1, 1);
    send_eval(hfe_pkg::FT_TWO_V, 22, 23, 1, 1);
    send_eval(hfe_pkg::FT_TWO_H, 23, 23, 1, 1);
    send_eval(hfe_pkg::FT_THREE_V, 1, 0, 8, 1);
    send_eval(hfe_pkg::FT_THREE_H, 0, 0, 24, 9);
    send_eval(hfe_pkg::FT_TWO_V, 0, 0, 0, 4);
    send_eval(hfe_pkg::FT_TWO_H, 0, 0, 4, 0);
    send_eval(FT_NONE, 0, 0, 4, 4);
    send_eval(FT_SPARE_A, 0, 0, 4, 4);
    send_eval(FT_SPARE_B, 0, 0, 4, 4);
    send_eval(hfe_pkg::FT_CHECKER, 31, 31, 31, 31);
    // overwrite the start of the window, then read across old and new rows
    send_load(8'h01);
    send_load(8'h7f);
    send_eval(hfe_pkg::FT_TWO_V, 0, 0, 1, 2);

    wait_for_results();

    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      no_gaps = (words_sent - random_start >= 300) && (words_sent - random_start < 550);
      if (!mid_pause_done && words_sent - random_start >= 650) begin
        mid_pause_done = 1'b1;
        wait_for_results();
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        send_word(fitting_feature());
      end else if (roll < 68) begin
        send_word(random_word(hfe_pkg::KIND_EVAL));
      end else begin
        style = pix_style_t'($urandom_range(0, 3));
        burst = (roll == 68) ? CELLS - load_count : $urandom_range(1, WIN / 2);
        if (burst > RANDOM_WORDS - (words_sent - random_start)) begin
          burst = RANDOM_WORDS - (words_sent - random_start);
        end
        repeat (burst) send_load(pixel_for(style));
      end
    end
    no_gaps = 1'b0;

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/hfe_pkg.sv
design/hfe_ram.sv
design/hfe_front.sv
design/hfe_result_queue.sv
design/hfe_back.sv
design/haar_feature_evaluator_core.sv
dv/haar_feature_evaluator_core_tb.sv
